>>> design/trs_pkg.sv
package trs_pkg;

	localparam int COORD_W = 9;
	localparam int ROW_W = 10;
	localparam int LIM_W = 13;

	localparam int SCREEN_HEIGHT_DEF = 512;
	localparam int SCREEN_WIDTH_DEF = 512;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam logic [1:0] CORNER_TRIGGER = 2'd2;
	localparam logic [1:0] CORNER_NONE = 2'd3;

	localparam logic [1:0] EDGE_LONG = 2'd0;
	localparam logic [1:0] EDGE_LOW = 2'd1;
	localparam logic [1:0] EDGE_HIGH = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT,
		ST_AREA1,
		ST_AREA2,
		ST_EDGE,
		ST_DIV,
		ST_WALK,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic [1:0] we;
		logic re;
		logic div_go;
	} ctrl_t;

endpackage

>>> design/trs_span_mem.sv
module trs_span_mem #(
	parameter int DEPTH = trs_pkg::SCREEN_HEIGHT_DEF
) (
	input logic clk,
	input logic [1:0] we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [trs_pkg::COORD_W-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [2*trs_pkg::COORD_W-1:0] rdata
);
	import trs_pkg::*;

	logic [2*COORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we[0]) begin
			mem[waddr][COORD_W-1:0] <= wdata;
		end
		if (we[1]) begin
			mem[waddr][2*COORD_W-1:COORD_W] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/trs_divider.sv
module trs_divider #(
	parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [FRAC_BITS+trs_pkg::COORD_W-1:0] dividend,
	input logic [trs_pkg::COORD_W-1:0] divisor,
	output logic done,
	output logic [FRAC_BITS+trs_pkg::COORD_W-1:0] quotient
);
	import trs_pkg::*;

	localparam int DW = FRAC_BITS + COORD_W;
	localparam int CW = $clog2(DW + 1);

	logic run_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] q_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] div_q;
	logic [COORD_W:0] rem_sh;
	logic [COORD_W:0] rem_sub;
	logic fits;

	always_comb begin
		rem_sh = {rem_q, q_q[DW-1]};
		fits = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			q_q <= '0;
			rem_q <= '0;
			div_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
				q_q <= dividend;
				rem_q <= '0;
				div_q <= divisor;
			end else if (run_q) begin
				q_q <= {q_q[DW-2:0], fits};
				rem_q <= fits ? rem_sub[COORD_W-1:0] : rem_sh[COORD_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = q_q;

endmodule

>>> design/triangle_scanline_rasterizer.sv
// Channel  Direction  Handshake            Word
// input    in         start high, busy low op, corner, vert_x, vert_y
// result   out        pixel_valid strobe   pixel_x, pixel_y, last_pixel
//
// A vertex load of corner 0 or 1 and a tick that stays on its row are handled in the
// idle state. Loading corner 2 runs setup: the sort state and the area states, then
// per edge an edge state, the serial divider and a walk that writes the edge's rows to
// the span memory (a skipped edge takes only the edge state), then the row search below.
// A tick that leaves its row reads the span memory row by row until a covered pixel is
// found or the last row is passed. Reset is asynchronous and clears all control state.
// The receiver cannot stall; each result is shown for exactly one cycle.
module triangle_scanline_rasterizer #(
	parameter int SCREEN_HEIGHT = trs_pkg::SCREEN_HEIGHT_DEF,
	parameter int SCREEN_WIDTH = trs_pkg::SCREEN_WIDTH_DEF,
	parameter int FRAC_BITS = trs_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic op,
	input logic [1:0] corner,
	input logic [trs_pkg::COORD_W-1:0] vert_x,
	input logic [trs_pkg::COORD_W-1:0] vert_y,
	output logic pixel_valid,
	output logic [trs_pkg::COORD_W-1:0] pixel_x,
	output logic [trs_pkg::COORD_W-1:0] pixel_y,
	output logic last_pixel
);
	import trs_pkg::*;

	localparam int AW = $clog2(SCREEN_HEIGHT);
	localparam int DW = FRAC_BITS + COORD_W;
	localparam int ACC_W = FRAC_BITS + 11;
	localparam logic [LIM_W-1:0] H_LIM = LIM_W'(SCREEN_HEIGHT);
	localparam logic [LIM_W-1:0] W_LIM = LIM_W'(SCREEN_WIDTH);

	state_t state_q, state_n;
	ctrl_t ctrl;

	logic [COORD_W-1:0] vx_q [3];
	logic [COORD_W-1:0] vy_q [3];
	logic [COORD_W-1:0] sx_q [3];
	logic [COORD_W-1:0] sy_q [3];
	logic [COORD_W-1:0] tx [3];
	logic [COORD_W-1:0] ty [3];
	logic [COORD_W-1:0] tmp;
	logic signed [21:0] prod_q;
	logic signed [21:0] area;
	logic side_q;
	logic [1:0] edge_q;
	logic [COORD_W-1:0] y_q;
	logic signed [ACC_W-1:0] acc_q;
	logic neg_q;
	logic [ROW_W-1:0] fill_row_q, fill_col_q, end_row_q, cur_end_q;
	logic filling_q, pend_q;
	logic [COORD_W-1:0] pend_x_q, pend_y_q;
	logic valid_q, last_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;

	logic accept, fast, skip, walk_end, in_range, found;
	logic [COORD_W-1:0] ax, ay, bx, by, abs_dx, wx;
	logic col;
	logic [DW-1:0] quotient;
	logic div_done;
	logic signed [ACC_W-1:0] step;
	logic [2*COORD_W-1:0] rdata;
	logic [COORD_W-1:0] st;
	logic [LIM_W-1:0] e_raw;
	logic [ROW_W-1:0] en;

	always_comb begin
		tx = vx_q;
		ty = vy_q;
		tmp = '0;
		if (ty[1] < ty[0]) begin
			tmp = tx[0]; tx[0] = tx[1]; tx[1] = tmp;
			tmp = ty[0]; ty[0] = ty[1]; ty[1] = tmp;
		end
		if (ty[2] < ty[1]) begin
			tmp = tx[1]; tx[1] = tx[2]; tx[2] = tmp;
			tmp = ty[1]; ty[1] = ty[2]; ty[2] = tmp;
		end
		if (ty[1] < ty[0]) begin
			tmp = tx[0]; tx[0] = tx[1]; tx[1] = tmp;
			tmp = ty[0]; ty[0] = ty[1]; ty[1] = tmp;
		end
	end

	assign area = prod_q - (($signed({2'b0, sx_q[1]}) - $signed({2'b0, sx_q[0]}))
		* ($signed({2'b0, sy_q[2]}) - $signed({2'b0, sy_q[0]})));

	always_comb begin
		case (edge_q)
			EDGE_LONG: begin
				ax = sx_q[0]; ay = sy_q[0]; bx = sx_q[2]; by = sy_q[2]; col = side_q;
			end
			EDGE_LOW: begin
				ax = sx_q[0]; ay = sy_q[0]; bx = sx_q[1]; by = sy_q[1]; col = ~side_q;
			end
			default: begin
				ax = sx_q[1]; ay = sy_q[1]; bx = sx_q[2]; by = sy_q[2]; col = ~side_q;
			end
		endcase
		abs_dx = (bx < ax) ? (ax - bx) : (bx - ax);
		skip = by <= ay;
		walk_end = ({1'b0, y_q} + 1'b1) == {1'b0, by};
		step = neg_q ? -$signed(ACC_W'(quotient)) : $signed(ACC_W'(quotient));
		wx = acc_q[ACC_W-1] ? '0 : acc_q[FRAC_BITS+COORD_W-1:FRAC_BITS];
	end

	always_comb begin
		in_range = LIM_W'(fill_row_q) < H_LIM;
		st = in_range ? rdata[COORD_W-1:0] : '0;
		e_raw = in_range ? LIM_W'(rdata[2*COORD_W-1:COORD_W]) : '0;
		en = (e_raw > W_LIM) ? ROW_W'(W_LIM) : ROW_W'(e_raw);
		found = ROW_W'(st) < en;
		accept = start && !busy;
		fast = (fill_col_q + 1'b1) < cur_end_q;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_LOAD && corner == CORNER_TRIGGER) begin
					state_n = ST_SORT;
				end else if (accept && op == OP_TICK && filling_q && !fast) begin
					state_n = ST_READ;
				end
			end
			ST_SORT: state_n = ST_AREA1;
			ST_AREA1: state_n = ST_AREA2;
			ST_AREA2: state_n = ST_EDGE;
			ST_EDGE: begin
				if (!skip) begin
					state_n = ST_DIV;
				end else if (edge_q == EDGE_HIGH) begin
					state_n = ST_READ;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_n = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_n = (edge_q == EDGE_HIGH) ? ST_READ : ST_EDGE;
				end
			end
			ST_READ: begin
				state_n = (fill_row_q >= end_row_q) ? ST_IDLE : ST_CHECK;
			end
			ST_CHECK: state_n = found ? ST_IDLE : ST_READ;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != ST_IDLE;
		ctrl.re = state_q == ST_READ && fill_row_q < end_row_q;
		ctrl.div_go = state_q == ST_EDGE && !skip;
		ctrl.we = '0;
		if (state_q == ST_WALK && LIM_W'(y_q) < H_LIM) begin
			ctrl.we = col ? 2'b10 : 2'b01;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
				sx_q[i] <= '0;
				sy_q[i] <= '0;
			end
			prod_q <= '0;
			side_q <= 1'b0;
			edge_q <= EDGE_LONG;
			y_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			fill_row_q <= '0;
			fill_col_q <= '0;
			end_row_q <= '0;
			cur_end_q <= '0;
			filling_q <= 1'b0;
			pend_q <= 1'b0;
			pend_x_q <= '0;
			pend_y_q <= '0;
			valid_q <= 1'b0;
			last_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
		end else begin
			state_q <= state_n;
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_LOAD && corner != CORNER_NONE) begin
						vx_q[corner] <= vert_x;
						vy_q[corner] <= vert_y;
					end
					if (accept && op == OP_TICK && filling_q) begin
						if (fast) begin
							valid_q <= 1'b1;
							last_q <= 1'b0;
							out_x_q <= fill_col_q[COORD_W-1:0];
							out_y_q <= fill_row_q[COORD_W-1:0];
							fill_col_q <= fill_col_q + 1'b1;
						end else begin
							pend_q <= 1'b1;
							pend_x_q <= fill_col_q[COORD_W-1:0];
							pend_y_q <= fill_row_q[COORD_W-1:0];
							fill_row_q <= fill_row_q + 1'b1;
						end
					end
				end
				ST_SORT: begin
					sx_q <= tx;
					sy_q <= ty;
					filling_q <= 1'b0;
					pend_q <= 1'b0;
				end
				ST_AREA1: begin
					prod_q <= ($signed({2'b0, sx_q[2]}) - $signed({2'b0, sx_q[0]}))
						* ($signed({2'b0, sy_q[1]}) - $signed({2'b0, sy_q[0]}));
				end
				ST_AREA2: begin
					side_q <= ~area[21];
					edge_q <= EDGE_LONG;
					fill_row_q <= ROW_W'(sy_q[0]);
					end_row_q <= ROW_W'(sy_q[2]);
				end
				ST_EDGE: begin
					neg_q <= bx < ax;
					y_q <= ay;
					acc_q <= $signed(ACC_W'(ax)) <<< FRAC_BITS;
					if (skip) begin
						edge_q <= edge_q + 1'b1;
					end
				end
				ST_DIV: begin
				end
				ST_WALK: begin
					acc_q <= acc_q + step;
					y_q <= y_q + 1'b1;
					if (walk_end) begin
						edge_q <= edge_q + 1'b1;
					end
				end
				ST_READ: begin
					if (fill_row_q >= end_row_q) begin
						filling_q <= 1'b0;
						if (pend_q) begin
							valid_q <= 1'b1;
							last_q <= 1'b1;
							out_x_q <= pend_x_q;
							out_y_q <= pend_y_q;
							pend_q <= 1'b0;
						end
					end
				end
				ST_CHECK: begin
					if (found) begin
						filling_q <= 1'b1;
						fill_col_q <= ROW_W'(st);
						cur_end_q <= en;
						if (pend_q) begin
							valid_q <= 1'b1;
							last_q <= 1'b0;
							out_x_q <= pend_x_q;
							out_y_q <= pend_y_q;
							pend_q <= 1'b0;
						end
					end else begin
						fill_row_q <= fill_row_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	trs_divider #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(ctrl.div_go),
		.dividend(DW'(abs_dx) << FRAC_BITS),
		.divisor(by - ay),
		.done(div_done),
		.quotient(quotient)
	);

	trs_span_mem #(
		.DEPTH(SCREEN_HEIGHT)
	) u_mem (
		.clk(clk),
		.we(ctrl.we),
		.waddr(AW'(y_q)),
		.wdata(wx),
		.re(ctrl.re),
		.raddr(AW'(fill_row_q)),
		.rdata(rdata)
	);

	assign pixel_valid = valid_q;
	assign pixel_x = out_x_q;
	assign pixel_y = out_y_q;
	assign last_pixel = last_q;

endmodule
